[sv/lobm_pkg.sv]
package lobm_pkg;

    // Book geometry and field widths
    localparam int BOOK_ENTRIES = 64;
    localparam int PRICE_BITS   = 16;
    localparam int QTY_BITS     = 24;
    localparam int ID_BITS      = 32;
    localparam int SEQ_BITS     = 32;
    localparam int MAX_RESULTS  = 64;

    localparam int IDX_W = $clog2(BOOK_ENTRIES);
    localparam int CNT_W = $clog2(BOOK_ENTRIES + 2);
    localparam int NTR_W = $clog2(MAX_RESULTS + 1);

    // Request kinds
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_CANCEL = 1'b1;

    // Order sides
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_BOOK_FULL = 2'd2;

    typedef struct packed {
        logic                  kind;
        logic                  side;
        logic [ID_BITS-1:0]    order_num;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   quantity;
    } req_t;

    typedef struct packed {
        logic                  trade_valid;
        logic [ID_BITS-1:0]    buy_id;
        logic [ID_BITS-1:0]    sell_id;
        logic [PRICE_BITS-1:0] trade_price;
        logic [QTY_BITS-1:0]   trade_qty;
        logic                  aggressor_side;
        logic [1:0]            status;
        logic [QTY_BITS-1:0]   rested_qty;
        logic [PRICE_BITS-1:0] bid_top;
        logic [PRICE_BITS-1:0] ask_top;
        logic [PRICE_BITS-1:0] spread;
        logic                  last;
    } rsp_t;

    // One resting order as held in the book memory
    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
        logic                  side;
        logic [SEQ_BITS-1:0]   seq;
    } entry_t;

endpackage

[sv/limit_order_book_matcher.sv]
// Price-time priority order book. Each request is taken while the block is
// idle; req_stall stays high until the request's last response has been
// loaded into the output register. The book memory has a single read port,
// so every pass over the book reads its BOOK_ENTRIES entries one by one.
// A cancel takes one pass to remove the id and one pass for the best bid/ask
// summary. An add with F fills takes one match pass per fill, one more match
// pass when quantity is still left after the last fill, one fill step per
// fill and a summary pass; a zero quantity add takes one summary pass.
// Responses are held in an output register, so a stalled consumer
// only delays the block at the moments it has a response to hand over.
module limit_order_book_matcher
    import lobm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MATCH  = 6'b000010,
        ST_FILL   = 6'b000100,
        ST_CANCEL = 6'b001000,
        ST_SUM    = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    localparam logic [CNT_W-1:0] SCAN_LEN = CNT_W'(BOOK_ENTRIES);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(BOOK_ENTRIES + 1);

    // Book memory
    entry_t book_mem [BOOK_ENTRIES];
    entry_t rd_data_reg;

    // Control state
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [BOOK_ENTRIES-1:0] valid_reg, valid_next;
    logic [SEQ_BITS-1:0]     arrival_reg, arrival_next;
    logic                    rsp_valid_reg;

    // Request context
    req_t                    req_q_reg, req_q_next;
    logic [SEQ_BITS-1:0]     seq_cur_reg, seq_cur_next;
    logic [QTY_BITS-1:0]     remain_reg, remain_next;
    logic [NTR_W-1:0]        ntr_reg, ntr_next;
    logic [1:0]              status_reg, status_next;
    logic [QTY_BITS-1:0]     rested_reg, rested_next;
    logic                    cxl_found_reg, cxl_found_next;

    // Match scan accumulators
    logic                    found_reg, found_next;
    entry_t                  best_ent_reg, best_ent_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [SEQ_BITS-1:0]     best_age_reg, best_age_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;

    // Summary scan accumulators
    logic                    hb_reg, hb_next;
    logic                    ha_reg, ha_next;
    logic [PRICE_BITS-1:0]   bb_reg, bb_next;
    logic [PRICE_BITS-1:0]   ba_reg, ba_next;

    // Trade held back until it is known whether it is the last one
    logic                    pend_valid_reg, pend_valid_next;
    logic [ID_BITS-1:0]      pend_buy_reg, pend_buy_next;
    logic [ID_BITS-1:0]      pend_sell_reg, pend_sell_next;
    logic [PRICE_BITS-1:0]   pend_price_reg, pend_price_next;
    logic [QTY_BITS-1:0]     pend_qty_reg, pend_qty_next;

    rsp_t                    rsp_reg;

    // Datapath helpers
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_wa;
    entry_t                  mem_wd;
    logic                    can_emit;
    logic                    emit;
    rsp_t                    emit_data;
    logic                    ent_v;
    logic [SEQ_BITS-1:0]     age;
    logic                    price_ok;
    logic                    better;
    logic [QTY_BITS-1:0]     fill;
    logic [QTY_BITS-1:0]     left;
    logic [PRICE_BITS-1:0]   spread_val;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign can_emit  = !rsp_valid_reg || !rsp_stall;

    // One entry read per cycle while scanning
    assign rd_en   = ((state_reg == ST_MATCH) || (state_reg == ST_CANCEL) ||
                      (state_reg == ST_SUM)) && (cnt_reg < SCAN_LEN);
    assign rd_addr = cnt_reg[IDX_W-1:0];

    // Per-entry compare on the registered read data
    assign ent_v    = valid_reg[rd_idx_reg];
    assign age      = seq_cur_reg - rd_data_reg.seq;
    assign price_ok = (req_q_reg.side == SIDE_BUY) ? (rd_data_reg.price <= req_q_reg.price)
                                                   : (rd_data_reg.price >= req_q_reg.price);
    assign better   = !found_reg ||
                      ((req_q_reg.side == SIDE_BUY) ? (rd_data_reg.price < best_ent_reg.price)
                                                    : (rd_data_reg.price > best_ent_reg.price)) ||
                      ((rd_data_reg.price == best_ent_reg.price) && (age > best_age_reg));

    // Fill against the chosen resting order
    assign fill = (remain_reg < best_ent_reg.qty) ? remain_reg : best_ent_reg.qty;
    assign left = best_ent_reg.qty - fill;

    assign spread_val = (hb_reg && ha_reg && (ba_reg >= bb_reg)) ? (ba_reg - bb_reg) : '0;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = rd_en;
        rd_idx_next     = rd_addr;
        valid_next      = valid_reg;
        arrival_next    = arrival_reg;
        req_q_next      = req_q_reg;
        seq_cur_next    = seq_cur_reg;
        remain_next     = remain_reg;
        ntr_next        = ntr_reg;
        status_next     = status_reg;
        rested_next     = rested_reg;
        cxl_found_next  = cxl_found_reg;
        found_next      = found_reg;
        best_ent_next   = best_ent_reg;
        best_idx_next   = best_idx_reg;
        best_age_next   = best_age_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hb_next         = hb_reg;
        ha_next         = ha_reg;
        bb_next         = bb_reg;
        ba_next         = ba_reg;
        pend_valid_next = pend_valid_reg;
        pend_buy_next   = pend_buy_reg;
        pend_sell_next  = pend_sell_reg;
        pend_price_next = pend_price_reg;
        pend_qty_next   = pend_qty_reg;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = '0;
        emit            = 1'b0;
        emit_data       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_q_next      = req;
                    cnt_next        = '0;
                    status_next     = STAT_OK;
                    rested_next     = '0;
                    cxl_found_next  = 1'b0;
                    pend_valid_next = 1'b0;
                    ntr_next        = '0;
                    remain_next     = req.quantity;
                    if (req.kind == KIND_CANCEL)
                    begin
                        state_next = ST_CANCEL;
                    end
                    else
                    begin
                        seq_cur_next = arrival_reg;
                        arrival_next = arrival_reg + 1'b1;
                        state_next   = (req.quantity == '0) ? ST_SUM : ST_MATCH;
                    end
                end
            end

            ST_MATCH:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '0)
                begin
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                end
                if (rd_vld_reg)
                begin
                    if (ent_v && (rd_data_reg.side != req_q_reg.side) && price_ok && better)
                    begin
                        found_next    = 1'b1;
                        best_ent_next = rd_data_reg;
                        best_idx_next = rd_idx_reg;
                        best_age_next = age;
                    end
                    if (!ent_v && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                end
                if (cnt_reg == SCAN_END)
                begin
                    cnt_next = '0;
                    if (found_reg && (ntr_reg < NTR_W'(MAX_RESULTS)))
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_SUM;
                        if (found_reg || !free_found_reg)
                        begin
                            status_next = STAT_BOOK_FULL;
                        end
                        else
                        begin
                            // rest the remainder in the first free entry
                            mem_we                  = 1'b1;
                            mem_wa                  = free_idx_reg;
                            mem_wd.id               = req_q_reg.order_num;
                            mem_wd.price            = req_q_reg.price;
                            mem_wd.qty              = remain_reg;
                            mem_wd.side             = req_q_reg.side;
                            mem_wd.seq              = seq_cur_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            rested_next             = remain_reg;
                        end
                    end
                end
            end

            ST_FILL:
            begin
                if (!pend_valid_reg || can_emit)
                begin
                    // earlier trade is now known not to be last
                    if (pend_valid_reg)
                    begin
                        emit                     = 1'b1;
                        emit_data.trade_valid    = 1'b1;
                        emit_data.buy_id         = pend_buy_reg;
                        emit_data.sell_id        = pend_sell_reg;
                        emit_data.trade_price    = pend_price_reg;
                        emit_data.trade_qty      = pend_qty_reg;
                        emit_data.aggressor_side = req_q_reg.side;
                    end
                    mem_we     = 1'b1;
                    mem_wa     = best_idx_reg;
                    mem_wd     = best_ent_reg;
                    mem_wd.qty = left;
                    if (left == '0)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_buy_next   = (req_q_reg.side == SIDE_BUY) ? req_q_reg.order_num
                                                                   : best_ent_reg.id;
                    pend_sell_next  = (req_q_reg.side == SIDE_BUY) ? best_ent_reg.id
                                                                   : req_q_reg.order_num;
                    pend_price_next = best_ent_reg.price;
                    pend_qty_next   = fill;
                    ntr_next        = ntr_reg + 1'b1;
                    remain_next     = remain_reg - fill;
                    cnt_next        = '0;
                    state_next      = (remain_reg == fill) ? ST_SUM : ST_MATCH;
                end
            end

            ST_CANCEL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (rd_vld_reg && ent_v && (rd_data_reg.id == req_q_reg.order_num))
                begin
                    valid_next[rd_idx_reg] = 1'b0;
                    cxl_found_next         = 1'b1;
                end
                if (cnt_reg == SCAN_END)
                begin
                    cnt_next    = '0;
                    status_next = cxl_found_reg ? STAT_OK : STAT_NOT_FOUND;
                    state_next  = ST_SUM;
                end
            end

            ST_SUM:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '0)
                begin
                    hb_next = 1'b0;
                    ha_next = 1'b0;
                    bb_next = '0;
                    ba_next = '0;
                end
                if (rd_vld_reg && ent_v)
                begin
                    if (rd_data_reg.side == SIDE_BUY)
                    begin
                        hb_next = 1'b1;
                        if (!hb_reg || (rd_data_reg.price > bb_reg))
                        begin
                            bb_next = rd_data_reg.price;
                        end
                    end
                    else
                    begin
                        ha_next = 1'b1;
                        if (!ha_reg || (rd_data_reg.price < ba_reg))
                        begin
                            ba_next = rd_data_reg.price;
                        end
                    end
                end
                if (cnt_reg == SCAN_END)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (can_emit)
                begin
                    emit                     = 1'b1;
                    emit_data.trade_valid    = pend_valid_reg;
                    emit_data.buy_id         = pend_valid_reg ? pend_buy_reg : '0;
                    emit_data.sell_id        = pend_valid_reg ? pend_sell_reg : '0;
                    emit_data.trade_price    = pend_valid_reg ? pend_price_reg : '0;
                    emit_data.trade_qty      = pend_valid_reg ? pend_qty_reg : '0;
                    emit_data.aggressor_side = (req_q_reg.kind == KIND_ADD) ? req_q_reg.side
                                                                             : SIDE_BUY;
                    emit_data.status         = status_reg;
                    emit_data.rested_qty     = rested_reg;
                    emit_data.bid_top        = bb_reg;
                    emit_data.ask_top        = ba_reg;
                    emit_data.spread         = spread_val;
                    emit_data.last           = 1'b1;
                    pend_valid_next          = 1'b0;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Book memory: at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            book_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= book_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            valid_reg      <= '0;
            arrival_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_vld_reg     <= rd_vld_next;
            valid_reg      <= valid_next;
            arrival_reg    <= arrival_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        req_q_reg      <= req_q_next;
        seq_cur_reg    <= seq_cur_next;
        remain_reg     <= remain_next;
        ntr_reg        <= ntr_next;
        status_reg     <= status_next;
        rested_reg     <= rested_next;
        cxl_found_reg  <= cxl_found_next;
        found_reg      <= found_next;
        best_ent_reg   <= best_ent_next;
        best_idx_reg   <= best_idx_next;
        best_age_reg   <= best_age_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        hb_reg         <= hb_next;
        ha_reg         <= ha_next;
        bb_reg         <= bb_next;
        ba_reg         <= ba_next;
        pend_buy_reg   <= pend_buy_next;
        pend_sell_reg  <= pend_sell_next;
        pend_price_reg <= pend_price_next;
        pend_qty_reg   <= pend_qty_next;
        if (emit)
        begin
            rsp_reg <= emit_data;
        end
    end

    // Checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_not_last_is_trade: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.last || rsp_reg.trade_valid))
        else $error("non-final response is not a trade");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start the sequencer");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> can_emit)
        else $error("response overwrote a stalled response");

endmodule

[tb/tb_limit_order_book_matcher.sv]
module tb_limit_order_book_matcher;
    import lobm_pkg::*;

    // Mirror of the order book: predicts every response of one request
    class book_scoreboard;
        bit                  live [BOOK_ENTRIES];
        bit [ID_BITS-1:0]    oid [BOOK_ENTRIES];
        bit [PRICE_BITS-1:0] px [BOOK_ENTRIES];
        bit [QTY_BITS-1:0]   qty [BOOK_ENTRIES];
        bit                  sd [BOOK_ENTRIES];
        bit [SEQ_BITS-1:0]   seq [BOOK_ENTRIES];
        bit [SEQ_BITS-1:0]   arrivals;
        rsp_t                expected_rsps [$];
        int                  errors;
        int                  trades_seen;
        int                  full_seen;
        int                  missing_seen;

        function new();
            arrivals = '0;
            errors = 0;
            trades_seen = 0;
            full_seen = 0;
            missing_seen = 0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        // Best resting order an incoming order may hit, -1 if none
        function int best_counter(bit s, bit [PRICE_BITS-1:0] p);
            int b;
            b = -1;
            for (int i = 0; i < BOOK_ENTRIES; i++) begin
                if (!live[i] || sd[i] == s)
                    continue;
                if (s == SIDE_BUY ? px[i] > p : px[i] < p)
                    continue;
                if (b < 0)
                    b = i;
                else if (s == SIDE_BUY ? px[i] < px[b] : px[i] > px[b])
                    b = i;
                else if (px[i] == px[b] &&
                         SEQ_BITS'(arrivals - seq[i]) > SEQ_BITS'(arrivals - seq[b]))
                    b = i;
            end
            return b;
        endfunction

        // Best bid, best ask and spread of the current book
        function void top_of_book(ref rsp_t e);
            bit hb, ha;
            bit [PRICE_BITS-1:0] b, a;
            hb = 0; ha = 0; b = '0; a = '0;
            for (int i = 0; i < BOOK_ENTRIES; i++) begin
                if (!live[i])
                    continue;
                if (sd[i] == SIDE_BUY) begin
                    if (!hb || px[i] > b) b = px[i];
                    hb = 1;
                end
                else begin
                    if (!ha || px[i] < a) a = px[i];
                    ha = 1;
                end
            end
            e.bid_top = b;
            e.ask_top = a;
            e.spread = (hb && ha && a >= b) ? a - b : '0;
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction

        // Note an accepted request and queue its expected responses
        function void accept_request(req_t r);
            rsp_t e;
            rsp_t fills [$];
            bit found;
            int m, slot;
            bit [QTY_BITS-1:0] rem, fill;
            e = '0;
            if (r.kind == KIND_CANCEL) begin
                found = 0;
                for (int i = 0; i < BOOK_ENTRIES; i++)
                    if (live[i] && oid[i] == r.order_num) begin
                        live[i] = 0;
                        found = 1;
                    end
                e.status = found ? STAT_OK : STAT_NOT_FOUND;
                e.last = 1;
                top_of_book(e);
                expected_rsps = {expected_rsps, e};
                return;
            end
            rem = r.quantity;
            while (rem > 0 && fills.size() < MAX_RESULTS) begin
                m = best_counter(r.side, r.price);
                if (m < 0)
                    break;
                fill = rem < qty[m] ? rem : qty[m];
                e = '0;
                e.trade_valid = 1;
                e.buy_id = r.side == SIDE_BUY ? r.order_num : oid[m];
                e.sell_id = r.side == SIDE_BUY ? oid[m] : r.order_num;
                e.trade_price = px[m];
                e.trade_qty = fill;
                e.aggressor_side = r.side;
                fills = {fills, e};
                rem -= fill;
                qty[m] -= fill;
                if (qty[m] == 0)
                    live[m] = 0;
            end
            e = fills.size() > 0 ? fills.pop_back() : '0;
            e.aggressor_side = r.side;
            if (rem > 0) begin
                slot = -1;
                if (fills.size() + 1 < MAX_RESULTS || best_counter(r.side, r.price) < 0)
                    for (int i = 0; i < BOOK_ENTRIES; i++)
                        if (!live[i] && slot < 0)
                            slot = i;
                if (slot >= 0) begin
                    live[slot] = 1;
                    oid[slot] = r.order_num;
                    px[slot] = r.price;
                    qty[slot] = rem;
                    sd[slot] = r.side;
                    seq[slot] = arrivals;
                    e.rested_qty = rem;
                end
                else begin
                    e.status = STAT_BOOK_FULL;
                end
            end
            arrivals += 1;
            e.last = 1;
            top_of_book(e);
            fills = {fills, e};
            foreach (fills[k])
                expected_rsps = {expected_rsps, fills[k]};
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // Compare one delivered response with the oldest expectation
        function void check_response(rsp_t a);
            rsp_t e;
            if (expected_rsps.size() == 0) begin
                errors++;
                $display("%0t: response with nothing expected, actual %h", $time, a);
                return;
            end
            e = expected_rsps.pop_front();
            if (a.trade_valid === 1'b1) trades_seen++;
            if (a.status === STAT_BOOK_FULL) full_seen++;
            if (a.status === STAT_NOT_FOUND) missing_seen++;
            compare_field("trade_valid", 64'(e.trade_valid), 64'(a.trade_valid));
            compare_field("buy_id", 64'(e.buy_id), 64'(a.buy_id));
            compare_field("sell_id", 64'(e.sell_id), 64'(a.sell_id));
            compare_field("trade_price", 64'(e.trade_price), 64'(a.trade_price));
            compare_field("trade_qty", 64'(e.trade_qty), 64'(a.trade_qty));
            compare_field("aggressor_side", 64'(e.aggressor_side), 64'(a.aggressor_side));
            compare_field("status", 64'(e.status), 64'(a.status));
            compare_field("rested_qty", 64'(e.rested_qty), 64'(a.rested_qty));
            compare_field("bid_top", 64'(e.bid_top), 64'(a.bid_top));
            compare_field("ask_top", 64'(e.ask_top), 64'(a.ask_top));
            compare_field("spread", 64'(e.spread), 64'(a.spread));
            compare_field("last", 64'(e.last), 64'(a.last));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_bus;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_bus;

    book_scoreboard sb;
    bit no_idle;
    int rsp_hold;
    int requests_sent;
    bit [ID_BITS-1:0] recent_ids [$];

    limit_order_book_matcher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_bus),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_bus)
    );

    always #5 clk = ~clk;

    // Response side: check accepted responses, draw a stall per response
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            sb.check_response(rsp_bus);
            rsp_hold = no_idle ? 0 : $urandom_range(0, 7);
        end
        if (rsp_hold > 0)
        begin
            rsp_stall <= 1'b1;
            rsp_hold--;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // Present one request after a random gap, return once accepted
    task send_request(input req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_bus <= r;
        do
            @(posedge clk);
        while (req_stall);
        sb.accept_request(r);
        requests_sent++;
        if (r.kind == KIND_ADD)
        begin
            recent_ids = {recent_ids, r.order_num};
            if (recent_ids.size() > 80)
                void'(recent_ids.pop_front());
        end
    endtask

    task send_add(input bit s, input bit [ID_BITS-1:0] id,
                  input bit [PRICE_BITS-1:0] p, input bit [QTY_BITS-1:0] q);
        req_t r;
        r.kind = KIND_ADD;
        r.side = s;
        r.order_num = id;
        r.price = p;
        r.quantity = q;
        send_request(r);
    endtask

    task send_cancel(input bit [ID_BITS-1:0] id);
        req_t r;
        r.kind = KIND_CANCEL;
        r.side = 1'($urandom_range(0, 1));
        r.order_num = id;
        r.price = PRICE_BITS'($urandom);
        r.quantity = QTY_BITS'($urandom);
        send_request(r);
    endtask

    // Drop valid and wait until every expected response has come back
    task wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() > 0);
    endtask

    // Watchdog
    initial
    begin
        #40000000;
        $display("limit_order_book_matcher: mismatch");
        $finish;
    end

    initial
    begin
        int mode;
        int band;
        bit [QTY_BITS-1:0] q;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_bus = '0;
        rsp_stall = 1'b0;
        rsp_hold = 0;
        no_idle = 1'b0;
        requests_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty book, zero quantity, price extremes, duplicates
        send_cancel(32'h0000_0001);
        send_add(SIDE_BUY, 32'hFFFF_FFFF, 16'h0000, 24'd0);
        send_add(SIDE_BUY, 32'h0000_0010, 16'h0000, 24'd5);
        send_add(SIDE_SELL, 32'h0000_0011, 16'hFFFF, 24'hFFFFFF);
        send_add(SIDE_SELL, 32'h0000_0012, 16'd100, 24'd3);
        send_add(SIDE_SELL, 32'h0000_0013, 16'd100, 24'd4);
        send_add(SIDE_SELL, 32'h0000_0014, 16'd90, 24'd2);
        send_add(SIDE_BUY, 32'h0000_0015, 16'd100, 24'd7);
        send_add(SIDE_BUY, 32'h0000_0016, 16'hFFFF, 24'd10);
        send_add(SIDE_SELL, 32'h0000_0017, 16'h0000, 24'd20);
        send_add(SIDE_BUY, 32'h0000_0018, 16'd50, 24'd1);
        send_add(SIDE_BUY, 32'h0000_0018, 16'd60, 24'd1);
        send_cancel(32'h0000_0018);
        send_cancel(32'h0000_0018);
        send_cancel(32'h0000_0011);
        send_add(SIDE_SELL, 32'hFFFF_FFFE, 16'd0, 24'hFFFFFF);

        // Hold off until the book has answered everything
        wait_drained();

        // Random phases: build, mixed, cancel, sweep
        while (requests_sent < 200)
        begin
            mode = $urandom_range(0, 3);
            band = $urandom_range(200, 65300);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(12, 30))
            begin
                q = ($urandom_range(0, 15) == 0) ? QTY_BITS'($urandom)
                                                  : QTY_BITS'($urandom_range(1, 60));
                case (mode)
                    0: if ($urandom_range(0, 1))
                           send_add(SIDE_BUY, $urandom,
                                    PRICE_BITS'(band - $urandom_range(1, 40)), q);
                       else
                           send_add(SIDE_SELL, $urandom,
                                    PRICE_BITS'(band + $urandom_range(1, 40)), q);
                    1: send_add(1'($urandom_range(0, 1)), $urandom,
                                PRICE_BITS'(band + $urandom_range(0, 80) - 40), q);
                    2: if (recent_ids.size() > 0 && $urandom_range(0, 3) != 0)
                           send_cancel(recent_ids[$urandom_range(0, recent_ids.size() - 1)]);
                       else
                           send_cancel($urandom);
                    default:
                        if ($urandom_range(0, 1))
                            send_add(SIDE_BUY, $urandom, 16'hFFFF, QTY_BITS'($urandom));
                        else
                            send_add(SIDE_SELL, $urandom, 16'h0000, QTY_BITS'($urandom));
                endcase
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (200) @(posedge clk);
        $display("Covered %0d requests: %0d trades, %0d book-full and %0d not-found results.",
                 requests_sent, sb.trades_seen, sb.full_seen, sb.missing_seen);
        $display("Stalls and gaps of 0 to 7 cycles on both sides, with idle-free stretches.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("limit_order_book_matcher: match");
        else
            $display("limit_order_book_matcher: mismatch");
        $finish;
    end

endmodule

[filelist.f]
sv/lobm_pkg.sv
sv/limit_order_book_matcher.sv
tb/tb_limit_order_book_matcher.sv
